@@ sv/prc_pkg.sv @@
// Shared types, constants and functions of the prime range counter.
package prc_pkg;

    // Fixed field width of range bounds and counts
    localparam int FIELD_W = 21;
    localparam int WORD_W  = 64;

    typedef logic [FIELD_W-1:0] field_t;
    typedef logic [WORD_W-1:0]  bm_word_t;

    // Controller states: bitmap build, prefix build, query
    typedef enum logic [3:0] {
        ST_INIT,
        ST_BASE_RD,
        ST_BASE_CHK,
        ST_MARK_RD,
        ST_MARK_WR,
        ST_PF_RD,
        ST_PF_POP,
        ST_PF_WR,
        ST_IDLE,
        ST_Q_HI,
        ST_Q_LO,
        ST_Q_CNT,
        ST_Q_OUT
    } prc_state_t;

    // One result item from the core to the output stage
    typedef struct packed {
        logic   out_of_range;
        field_t prime_count;
    } prc_result_t;

    // Population count of a 64-bit word: per-byte counts, then one sum
    function automatic logic [6:0] popcount64(input bm_word_t w);
        logic [3:0] byte_cnt [8];
        logic [6:0] total;
        for (int b = 0; b < 8; b++) begin
            byte_cnt[b] = 4'(w[8*b+0]) + 4'(w[8*b+1]) + 4'(w[8*b+2]) + 4'(w[8*b+3])
                        + 4'(w[8*b+4]) + 4'(w[8*b+5]) + 4'(w[8*b+6]) + 4'(w[8*b+7]);
        end
        total = 7'(byte_cnt[0]) + 7'(byte_cnt[1]) + 7'(byte_cnt[2]) + 7'(byte_cnt[3])
              + 7'(byte_cnt[4]) + 7'(byte_cnt[5]) + 7'(byte_cnt[6]) + 7'(byte_cnt[7]);
        return total;
    endfunction

    // Mask of the bits strictly below a bit offset
    function automatic bm_word_t low_mask(input logic [5:0] off);
        return (bm_word_t'(1) << off) - bm_word_t'(1);
    endfunction

endpackage

@@ sv/prc_ram.sv @@
// Single-port-write, single-port-read synchronous RAM with registered read data.
module prc_ram #(
    parameter int DEPTH = 16385,
    parameter int DW    = 64,
    parameter int AW    = 15
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port with registered read data
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/prc_core.sv @@
// Sequencer: sieve build, prefix-count build and range queries over the two RAMs.
module prc_core #(
    parameter int LIMIT      = 1048576,
    parameter int BASE_LIMIT = 1024
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  prc_pkg::field_t      in_low,
    input  prc_pkg::field_t      in_high,
    output logic                 res_valid,
    input  logic                 res_ready,
    output prc_pkg::prc_result_t res
);

    import prc_pkg::*;

    localparam int WORDS  = (LIMIT / 64) + 1;
    localparam int AW     = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int PAW    = $clog2(WORDS + 1);
    localparam int CW     = $clog2(LIMIT + 2);
    localparam int NW_MIN = $clog2(LIMIT + BASE_LIMIT + 2);
    localparam int NW     = (NW_MIN > FIELD_W + 1) ? NW_MIN : FIELD_W + 1;
    localparam int IW     = $clog2(BASE_LIMIT + 2);
    localparam int SW     = (2 * IW > NW) ? 2 * IW : NW;
    localparam int LIMIT_OFF = LIMIT % 64;

    // Bits above LIMIT in the last word, and numbers 0 and 1 in the first
    localparam bm_word_t TAIL_MASK = ~((bm_word_t'(2) << LIMIT_OFF) - bm_word_t'(1));
    localparam bm_word_t HEAD_MASK = bm_word_t'(3);

    // Memory ports
    logic           bm_wr_en;
    logic [AW-1:0]  bm_wr_addr;
    bm_word_t       bm_wr_data;
    logic [AW-1:0]  bm_rd_addr;
    bm_word_t       bm_rd;
    logic           pf_wr_en;
    logic [PAW-1:0] pf_wr_addr;
    logic [CW-1:0]  pf_wr_data;
    logic [PAW-1:0] pf_rd_addr;
    logic [CW-1:0]  pf_rd;

    // State
    prc_state_t     state_reg, state_next;
    logic [PAW-1:0] k_reg, k_next;
    logic [IW-1:0]  i_reg, i_next;
    logic [2*IW-1:0] sq_reg, sq_next;
    logic [NW-1:0]  j_reg, j_next;
    logic [CW-1:0]  acc_reg, acc_next;
    logic [6:0]     pop_reg, pop_next;
    logic [NW-1:0]  lo_reg, lo_next;
    logic [NW-1:0]  nhi_reg, nhi_next;
    logic           oor_reg, oor_next;
    logic           empty_reg, empty_next;
    logic [CW-1:0]  cnt_hi_reg, cnt_hi_next;
    logic [CW-1:0]  cnt_lo_reg, cnt_lo_next;

    // Helpers
    logic [NW-1:0]  i_n;
    logic [NW-1:0]  j_step;
    logic [NW-1:0]  hi_in;
    logic [NW-1:0]  hi_clamp;
    logic           hi_over;
    bm_word_t       init_word;
    logic [CW-1:0]  part_cnt;
    logic [5:0]     part_off;

    prc_ram #(.DEPTH(WORDS), .DW(WORD_W), .AW(AW)) u_bitmap (
        .aclk   (aclk),
        .wr_en  (bm_wr_en),
        .wr_addr(bm_wr_addr),
        .wr_data(bm_wr_data),
        .rd_addr(bm_rd_addr),
        .rd_data(bm_rd)
    );

    prc_ram #(.DEPTH(WORDS + 1), .DW(CW), .AW(PAW)) u_prefix (
        .aclk   (aclk),
        .wr_en  (pf_wr_en),
        .wr_addr(pf_wr_addr),
        .wr_data(pf_wr_data),
        .rd_addr(pf_rd_addr),
        .rd_data(pf_rd)
    );

    assign i_n      = NW'(i_reg);
    assign j_step   = j_reg + i_n;
    assign hi_in    = NW'(in_high);
    assign hi_over  = hi_in > NW'(LIMIT);
    assign hi_clamp = hi_over ? NW'(LIMIT) : hi_in;

    // Initial bitmap word for the clearing pass
    always_comb begin
        init_word = '0;
        if (k_reg == PAW'(WORDS - 1)) begin
            init_word = init_word | TAIL_MASK;
        end
        if (k_reg == '0) begin
            init_word = init_word | HEAD_MASK;
        end
    end

    // primes below n: prefix of its word plus set-free bits under its offset
    assign part_off = (state_reg == ST_Q_LO) ? nhi_reg[5:0] : lo_reg[5:0];
    assign part_cnt = pf_rd + CW'(popcount64(~bm_rd & low_mask(part_off)));

    // State register and datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            k_reg     <= k_next;
        end
        i_reg      <= i_next;
        sq_reg     <= sq_next;
        j_reg      <= j_next;
        acc_reg    <= acc_next;
        pop_reg    <= pop_next;
        lo_reg     <= lo_next;
        nhi_reg    <= nhi_next;
        oor_reg    <= oor_next;
        empty_reg  <= empty_next;
        cnt_hi_reg <= cnt_hi_next;
        cnt_lo_reg <= cnt_lo_next;
    end

    // Next state, memory control and outputs
    always_comb begin
        state_next  = state_reg;
        k_next      = k_reg;
        i_next      = i_reg;
        sq_next     = sq_reg;
        j_next      = j_reg;
        acc_next    = acc_reg;
        pop_next    = pop_reg;
        lo_next     = lo_reg;
        nhi_next    = nhi_reg;
        oor_next    = oor_reg;
        empty_next  = empty_reg;
        cnt_hi_next = cnt_hi_reg;
        cnt_lo_next = cnt_lo_reg;

        bm_wr_en   = 1'b0;
        bm_wr_addr = k_reg[AW-1:0];
        bm_wr_data = init_word;
        bm_rd_addr = k_reg[AW-1:0];
        pf_wr_en   = 1'b0;
        pf_wr_addr = '0;
        pf_wr_data = '0;
        pf_rd_addr = '0;

        in_ready  = 1'b0;
        res_valid = 1'b0;
        res.out_of_range = oor_reg;
        res.prime_count  = empty_reg ? '0 : FIELD_W'(cnt_hi_reg - cnt_lo_reg);

        case (state_reg)
            // Clearing pass: seed every bitmap word, prefix[0] = 0
            ST_INIT: begin
                bm_wr_en = 1'b1;
                pf_wr_en = 1'b1;
                if (k_reg == PAW'(WORDS - 1)) begin
                    i_next     = IW'(2);
                    state_next = ST_BASE_RD;
                end else begin
                    k_next = k_reg + 1'b1;
                end
            end
            // Fetch the word holding base i, square it
            ST_BASE_RD: begin
                bm_rd_addr = i_n[6 +: AW];
                sq_next    = (2*IW)'(i_reg) * (2*IW)'(i_reg);
                state_next = ST_BASE_CHK;
            end
            ST_BASE_CHK: begin
                if (i_reg > IW'(BASE_LIMIT) || SW'(sq_reg) > SW'(LIMIT)) begin
                    k_next     = '0;
                    acc_next   = '0;
                    state_next = ST_PF_RD;
                end else if (!bm_rd[i_n[5:0]]) begin
                    j_next     = NW'(sq_reg);
                    state_next = ST_MARK_RD;
                end else begin
                    i_next     = i_reg + 1'b1;
                    state_next = ST_BASE_RD;
                end
            end
            // Read-modify-write of one multiple; read and write never overlap
            ST_MARK_RD: begin
                bm_rd_addr = j_reg[6 +: AW];
                state_next = ST_MARK_WR;
            end
            ST_MARK_WR: begin
                bm_wr_en   = 1'b1;
                bm_wr_addr = j_reg[6 +: AW];
                bm_wr_data = bm_rd | (bm_word_t'(1) << j_reg[5:0]);
                j_next     = j_step;
                if (j_step > NW'(LIMIT)) begin
                    i_next     = i_reg + 1'b1;
                    state_next = ST_BASE_RD;
                end else begin
                    state_next = ST_MARK_RD;
                end
            end
            // Prefix pass: prefix[k+1] = prefix[k] + primes in word k
            ST_PF_RD: begin
                bm_rd_addr = k_reg[AW-1:0];
                state_next = ST_PF_POP;
            end
            ST_PF_POP: begin
                pop_next   = popcount64(~bm_rd);
                state_next = ST_PF_WR;
            end
            ST_PF_WR: begin
                acc_next   = acc_reg + CW'(pop_reg);
                pf_wr_en   = 1'b1;
                pf_wr_addr = k_reg + 1'b1;
                pf_wr_data = acc_reg + CW'(pop_reg);
                if (k_reg == PAW'(WORDS - 1)) begin
                    state_next = ST_IDLE;
                end else begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_PF_RD;
                end
            end
            // Take a query: clamp the high bound, note an empty range
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    lo_next    = NW'(in_low);
                    nhi_next   = hi_clamp + 1'b1;
                    oor_next   = hi_over;
                    empty_next = NW'(in_low) > hi_clamp;
                    state_next = ST_Q_HI;
                end
            end
            ST_Q_HI: begin
                bm_rd_addr = nhi_reg[6 +: AW];
                pf_rd_addr = nhi_reg[6 +: PAW];
                state_next = ST_Q_LO;
            end
            ST_Q_LO: begin
                bm_rd_addr  = lo_reg[6 +: AW];
                pf_rd_addr  = lo_reg[6 +: PAW];
                cnt_hi_next = part_cnt;
                state_next  = ST_Q_CNT;
            end
            ST_Q_CNT: begin
                cnt_lo_next = part_cnt;
                state_next  = ST_Q_OUT;
            end
            ST_Q_OUT: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_INIT;
            end
        endcase
    end

    // A taken query always goes to the high-bound read next
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid && in_ready |=> state_reg == ST_Q_HI)
        else $error("query accept did not start the lookup");

    // Marking never writes a number above the limit
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_MARK_WR |-> j_reg <= NW'(LIMIT))
        else $error("sieve marked beyond limit");

    // Prefix counts never decrease
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_PF_WR |=> acc_reg >= $past(acc_reg))
        else $error("prefix count decreased");

    // A non-empty range never has fewer primes below high+1 than below low
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_Q_OUT && !empty_reg |-> cnt_hi_reg >= cnt_lo_reg)
        else $error("negative prime count");

endmodule

@@ sv/prime_range_counter.sv @@
// Top level of the prime range counter: stream ports, core and output register.
//
//  channel | dir | tdata fields (lowest bit up)              | width
//  s_      | in  | range_low[20:0], range_high[41:21]         | 48
//  m_      | out | prime_count[20:0], out_of_range[21]        | 24
//
//  After reset the block builds its tables and holds s_tready low: a clearing
//  pass over all WORDS words (WORDS = LIMIT/64 + 1), a read and a check per
//  sieve base and a read and a write per marked multiple, then a read, a
//  popcount and a write per word for the prefix counts. A query reads the
//  bitmap and prefix RAMs once per bound, then does the popcount/subtract steps.
//  The result sits in an output register; a stalled m_ side holds one result and
//  stops the core only when a second result is ready.
module prime_range_counter #(
    parameter int LIMIT      = 1048576,
    parameter int BASE_LIMIT = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // range_low[20:0], range_high[41:21], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // prime_count[20:0], out_of_range[21], zero pad
);

    import prc_pkg::*;

    logic        res_valid;
    logic        res_ready;
    prc_result_t res;

    logic        m_tvalid_reg, m_tvalid_next;
    prc_result_t m_res_reg, m_res_next;

    prc_core #(.LIMIT(LIMIT), .BASE_LIMIT(BASE_LIMIT)) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_low   (s_tdata[20:0]),
        .in_high  (s_tdata[41:21]),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res      (res)
    );

    // Output register: load when empty or being drained
    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_res_next    = m_res_reg;
        if (res_ready) begin
            m_tvalid_next = res_valid;
            if (res_valid) begin
                m_res_next = res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        m_res_reg <= m_res_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, m_res_reg.out_of_range, m_res_reg.prime_count};

endmodule
